// ===== rtl/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and the character map of the base64 encoder
// no dependencies; imported by every module of the encoder
`timescale 1ns / 1ps

package b64e_pkg;

	// one raw byte in, one character out
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} in_word_t;

	typedef struct packed {
		logic [7:0] code_char;
		logic       code_last;
	} out_word_t;

	// position inside the current three byte group
	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	localparam int JOB_CHARS = 4;

	// characters caused by one byte, handed from front to back
	typedef struct packed {
		logic [JOB_CHARS-1:0][7:0] chars;
		logic [1:0]                cnt_m1;
		logic                      last;
	} job_t;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_LOWER = 8'h61;
	localparam logic [7:0] CHAR_DIGIT = 8'h30;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// six bit value to its alphabet character
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] ext;
		ext = {2'b00, v};
		if (v < 6'd26) begin
			return CHAR_UPPER + ext;
		end else if (v < 6'd52) begin
			return CHAR_LOWER + ext - 8'd26;
		end else if (v < 6'd62) begin
			return CHAR_DIGIT + ext - 8'd52;
		end else if (v == 6'd62) begin
			return CHAR_PLUS;
		end else begin
			return CHAR_SLASH;
		end
	endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// b64e_front: takes raw bytes, tracks group phase and leftover bits, builds jobs
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_front import b64e_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  in_word_t byte_word,
	input  logic     q_full,
	output logic     q_push,
	output job_t     q_job
);

	phase_t     phase_q, phase_d;
	logic [3:0] left_q, left_d;
	logic [7:0] b;
	logic       fin;

	assign byte_stall = q_full;
	assign q_push     = byte_valid & ~q_full;
	assign b          = byte_word.data_byte;
	assign fin        = byte_word.is_final;

	// split the byte into characters for this phase
	always_comb begin
		q_job.chars  = {JOB_CHARS{CHAR_PAD}};
		q_job.cnt_m1 = 2'd0;
		q_job.last   = 1'b0;
		phase_d      = PH_0;
		left_d       = 4'd0;
		case (phase_q)
			PH_1: begin
				q_job.chars[0] = b64_sym({left_q[1:0], b[7:4]});
				if (fin) begin
					q_job.chars[1] = b64_sym({b[3:0], 2'b00});
					q_job.cnt_m1   = 2'd2;
					q_job.last     = 1'b1;
				end else begin
					phase_d = PH_2;
					left_d  = b[3:0];
				end
			end
			PH_2: begin
				q_job.chars[0] = b64_sym({left_q, b[7:6]});
				q_job.chars[1] = b64_sym(b[5:0]);
				q_job.cnt_m1   = 2'd1;
				q_job.last     = fin;
			end
			default: begin
				q_job.chars[0] = b64_sym(b[7:2]);
				if (fin) begin
					q_job.chars[1] = b64_sym({b[1:0], 4'b0000});
					q_job.cnt_m1   = 2'd3;
					q_job.last     = 1'b1;
				end else begin
					phase_d = PH_1;
					left_d  = {2'b00, b[1:0]};
				end
			end
		endcase
	end

	// group state advances on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			left_q  <= 4'd0;
		end else if (q_push) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

// ===== rtl/b64e_queue.sv =====
// b64e_queue: two entry job queue between front and back
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_queue import b64e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_job   = ent_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/b64e_back.sv =====
// b64e_back: walks the head job one character a cycle, unless char_stall holds the output, into the output register
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_back import b64e_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  job_t      head_job,
	output logic      pop,
	output logic      char_valid,
	input  logic      char_stall,
	output out_word_t char_word
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_q;
	logic       adv;
	logic       take;
	logic       at_end;

	assign adv        = ~out_valid_q | ~char_stall;
	assign take       = adv & head_valid;
	assign at_end     = (idx_q == head_job.cnt_m1);
	assign pop        = take & at_end;
	assign char_valid = out_valid_q;
	assign char_word  = out_q;

	// character index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= head_valid;
			end
			if (take) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.code_char <= head_job.chars[idx_q];
			out_q.code_last <= head_job.last & at_end;
		end
	end

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// base64_stream_encoder: streaming base64 encoder with '=' padding
// path: the first character of a byte passes through the job queue and then the output register
// throughput: one character per cycle at the output register while char_stall is low; a byte gives one to
// four characters, so byte intake is paced by the output port
// reset: arst_n clears group phase, leftover bits, job queue and output valid
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
`timescale 1ns / 1ps

module base64_stream_encoder import b64e_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_word_t  byte_word,
	output logic      char_valid,
	input  logic      char_stall,
	output out_word_t char_word
);

	logic q_full, q_push, q_pop, q_head_valid;
	job_t q_job, q_head;

	// byte intake and classification
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_job)
	);

	// decoupling queue
	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head)
	);

	// character output
	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head),
		.pop        (q_pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word)
	);

endmodule

// ===== sim/base64_stream_encoder_tb.sv =====
// base64_stream_encoder_tb: self-checking bench for the streaming base64 encoder
// depends on b64e_pkg and base64_stream_encoder; a scoreboard class predicts every character
`timescale 1ns / 1ps

// predicts the characters of each accepted byte and checks the output words in order
class b64_scoreboard;
	b64e_pkg::out_word_t expected_chars[$];
	b64e_pkg::phase_t    group_phase;
	logic [3:0]          leftover_bits;
	string               alphabet;
	int                  errors;
	int                  chars_checked;
	int                  bytes_taken;
	int                  messages;

	function new();
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		group_phase = b64e_pkg::PH_0;
		leftover_bits = 4'd0;
		errors = 0;
		chars_checked = 0;
		bytes_taken = 0;
		messages = 0;
	endfunction

	function logic [7:0] sym(logic [5:0] v);
		return alphabet[int'(v)];
	endfunction

	function void push_char(logic [7:0] c, logic last);
		b64e_pkg::out_word_t w;
		w.code_char = c;
		w.code_last = last;
		expected_chars.push_back(w);
	endfunction

	// one accepted byte: queue the characters it completes and advance the group
	function void take_byte(b64e_pkg::in_word_t w);
		logic [7:0] b;
		logic       fin;
		b = w.data_byte;
		fin = w.is_final;
		bytes_taken++;
		if (fin) begin
			messages++;
		end
		case (group_phase)
		b64e_pkg::PH_1: begin
			push_char(sym({leftover_bits[1:0], b[7:4]}), 1'b0);
			if (fin) begin
				push_char(sym({b[3:0], 2'b00}), 1'b0);
				push_char(b64e_pkg::CHAR_PAD, 1'b1);
				group_phase = b64e_pkg::PH_0;
				leftover_bits = 4'd0;
			end else begin
				group_phase = b64e_pkg::PH_2;
				leftover_bits = b[3:0];
			end
		end
		b64e_pkg::PH_2: begin
			push_char(sym({leftover_bits, b[7:6]}), 1'b0);
			push_char(sym(b[5:0]), fin);
			group_phase = b64e_pkg::PH_0;
			leftover_bits = 4'd0;
		end
		default: begin
			// start of a group
			push_char(sym(b[7:2]), 1'b0);
			if (fin) begin
				push_char(sym({b[1:0], 4'b0000}), 1'b0);
				push_char(b64e_pkg::CHAR_PAD, 1'b0);
				push_char(b64e_pkg::CHAR_PAD, 1'b1);
				group_phase = b64e_pkg::PH_0;
				leftover_bits = 4'd0;
			end else begin
				group_phase = b64e_pkg::PH_1;
				leftover_bits = {2'b00, b[1:0]};
			end
		end
		endcase
	endfunction

	// one accepted output word against the oldest expectation
	function void check_char(b64e_pkg::out_word_t got);
		b64e_pkg::out_word_t exp_w;
		chars_checked++;
		if (expected_chars.size() == 0) begin
			errors++;
			if (errors <= 20) begin
				$display("%0t: unexpected word, expected none, actual char %h last %b",
					$time, got.code_char, got.code_last);
			end
		end else begin
			exp_w = expected_chars.pop_front();
			if (got.code_char !== exp_w.code_char) begin
				errors++;
				if (errors <= 20) begin
					$display("%0t: code_char mismatch, expected %h actual %h",
						$time, exp_w.code_char, got.code_char);
				end
			end
			if (got.code_last !== exp_w.code_last) begin
				errors++;
				if (errors <= 20) begin
					$display("%0t: code_last mismatch, expected %b actual %b",
						$time, exp_w.code_last, got.code_last);
				end
			end
		end
	endfunction
endclass

module base64_stream_encoder_tb;
	import b64e_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 70;
	localparam int TAIL_BYTES   = 30;
	localparam int LONG_HOLD    = 120;
	localparam int PRESS_BYTES  = 30;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_word_t  byte_word = '0;
	logic      char_valid;
	logic      char_stall = 1'b0;
	out_word_t char_word;

	b64_scoreboard sb;
	bit quiet_tail = 1'b0;
	bit no_gaps = 1'b0;
	bit hold_request = 1'b0;
	int stall_left = 0;
	int input_stall_cycles = 0;

	// 4 ns clock
	always begin
		clk = 1'b0;
		#(CLK_HALF);
		clk = 1'b1;
		#(CLK_HALF);
	end

	base64_stream_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word)
	);

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				sb.take_byte(byte_word);
			end
			if (byte_valid && byte_stall) begin
				input_stall_cycles++;
			end
			if (char_valid && !char_stall) begin
				sb.check_char(char_word);
			end
		end
	end

	// output stall: random bursts, one long hold on request, none in the tail
	always @(negedge clk) begin
		if (!arst_n) begin
			char_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			char_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			stall_left = LONG_HOLD - 1;
			char_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 17);
			char_stall <= 1'b1;
		end else begin
			char_stall <= 1'b0;
		end
	end

	// offer one word at the falling edge and hold it until taken, then maybe idle
	task automatic send_byte(input logic [7:0] b, input logic fin);
		in_word_t w;
		w.data_byte = b;
		w.is_final = fin;
		byte_word <= w;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
		if (!quiet_tail && !no_gaps && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			byte_word <= in_word_t'($urandom);
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	initial begin
		int         msg_len;
		int         i;
		int         sent;
		logic [7:0] data;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one-byte messages: flush from the start of a group with two pads
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h01, 1'b1);
		// two-byte messages: flush from the middle of a group with one pad
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		// full groups ending a message: no padding, plus and slash
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAA, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// a group followed by a lone final byte
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b0);
		send_byte(8'h21, 1'b1);

		// receiver holds off while words keep coming, so the input backs up
		no_gaps = 1'b1;
		hold_request = 1'b1;
		for (i = 0; i < PRESS_BYTES; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == PRESS_BYTES - 1);
		end
		no_gaps = 1'b0;

		// random messages, mostly short, some long, extreme bytes now and then
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 16)
				: $urandom_range(1, 5);
			for (i = 0; i < msg_len; i++) begin
				if (RANDOM_BYTES - sent <= TAIL_BYTES) begin
					quiet_tail = 1'b1;
				end
				if ($urandom_range(0, 7) == 0) begin
					data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end else begin
					data = 8'($urandom_range(0, 255));
				end
				send_byte(data, i == msg_len - 1);
				sent++;
			end
		end
		byte_valid <= 1'b0;

		// drain, then keep clocking so that stray words can show
		while (sb.expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		$display("covered %0d bytes in %0d messages, %0d characters checked",
			sb.bytes_taken, sb.messages, sb.chars_checked);
		$display("input held back for %0d cycles, %0d errors",
			input_stall_cycles, sb.errors);
		if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
			$display("base64_stream_encoder_tb passed");
		end else begin
			$display("base64_stream_encoder_tb failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d words still expected",
			CYCLE_LIMIT, sb.expected_chars.size());
		$display("base64_stream_encoder_tb failed");
		$finish;
	end

endmodule
